[src/ipv6w_pkg.sv]
// ----------------------------------------------------------------------------
// ipv6w_pkg
// Shared types and constants of the IPv6 extension header walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6w_pkg;

  localparam int unsigned MaxPacketBytes = 65535;

  localparam logic [15:0] FixedHdrBytes = 16'd40;
  localparam logic [15:0] NextHdrPos    = 16'd6;
  localparam logic [15:0] MaxPosition   = 16'(MaxPacketBytes);
  localparam logic [16:0] HdrStartInit  = 17'd40;

  localparam logic [7:0] ExtHopByHop = 8'd0;
  localparam logic [7:0] ExtRouting  = 8'd43;
  localparam logic [7:0] ExtDestOpts = 8'd60;

  localparam int unsigned OutDataWidth = 48;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT_HDR = 2'd1,
    STATUS_TRUNC_EXT = 2'd2,
    STATUS_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [15:0] payload_offset;
    logic [7:0]  upper_protocol;
    status_t     status;
  } result_t;

  function automatic logic is_extension(input logic [7:0] t);
    is_extension = (t == ExtHopByHop) || (t == ExtRouting) || (t == ExtDestOpts);
  endfunction

endpackage

`default_nettype wire

[src/ipv6_ext_header_walker.sv]
// ----------------------------------------------------------------------------
// ipv6_ext_header_walker
// Walks the IPv6 extension header chain of a byte stream and reports the
// upper-layer protocol and payload position of each packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle, with tlast on the final byte, and
// sustains one byte every clock while the sink takes each summary. Each byte
// passes an input register, then the walk logic, and the summary of a packet
// is loaded into the output register when its last byte leaves the input
// register; a summary held by the sink stalls the input.
// Hop-by-Hop, Routing and Destination Options headers are skipped, and the
// status reports short headers, truncated extension headers and packets
// longer than the maximum size.
`default_nettype none

module ipv6_ext_header_walker import ipv6w_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [7:0]              in_tdata,   // data_byte[7:0]
  input  wire logic                    in_tlast,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // status[1:0], upper_protocol[9:2], payload_offset[25:10],
  // payload_length[41:26], zero fill above.
  output logic [OutDataWidth-1:0]      out_tdata
);

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_last;
  logic       fire;
  logic       res_valid;
  result_t    res;

  assign fire = byte_valid && advance;

  ipv6w_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_last  (byte_last)
  );

  ipv6w_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_data (byte_data),
    .byte_last (byte_last),
    .res_valid (res_valid),
    .res       (res)
  );

  ipv6w_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != STATUS_OK |->
      res.upper_protocol == 8'd0 && res.payload_offset == 16'd0 &&
      res.payload_length == 16'd0)
    else $error("error summary carries nonzero fields");

  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == STATUS_OK |->
      res.payload_offset >= FixedHdrBytes && !is_extension(res.upper_protocol))
    else $error("ok summary with bad offset or protocol");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_tvalid)
    else $error("summary not registered");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !fire)
    else $error("walker advanced while summary stalled");

endmodule

`default_nettype wire

[src/ipv6w_in_reg.sv]
// ----------------------------------------------------------------------------
// ipv6w_in_reg
// Input register that holds one packet byte until the walker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6w_in_reg import ipv6w_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       advance,
  output logic            byte_valid,
  output logic [7:0]      byte_data,
  output logic            byte_last
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;
  assign byte_last  = last_r;

endmodule

`default_nettype wire

[src/ipv6w_core.sv]
// ----------------------------------------------------------------------------
// ipv6w_core
// Walk state and the per-byte logic that follows the extension header chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6w_core import ipv6w_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] byte_data,
  input  wire logic       byte_last,
  output logic            res_valid,
  output result_t         res
);

  logic [15:0] byte_pos_r,  byte_pos_nxt;
  logic [7:0]  next_type_r, next_type_nxt;
  logic [16:0] hdr_start_r, hdr_start_nxt;
  logic        oversize_r,  oversize_nxt;
  logic [7:0]  pending_r,   pending_nxt;
  logic [16:0] pos_ext;
  logic [16:0] hdr_len;

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    next_type_nxt = next_type_r;
    hdr_start_nxt = hdr_start_r;
    oversize_nxt  = oversize_r;
    pending_nxt   = pending_r;
    pos_ext       = {1'b0, byte_pos_r};
    hdr_len       = {5'd0, ({1'b0, byte_data} + 9'd1), 3'd0};
    if (byte_pos_r >= MaxPosition) begin
      oversize_nxt = 1'b1;
    end else begin
      if (byte_pos_r == NextHdrPos) begin
        next_type_nxt = byte_data;
      end else if (byte_pos_r >= FixedHdrBytes && is_extension(next_type_r)) begin
        if (pos_ext == hdr_start_r) begin
          pending_nxt = byte_data;
        end else if (pos_ext == hdr_start_r + 17'd1) begin
          hdr_start_nxt = hdr_start_r + hdr_len;
          next_type_nxt = pending_r;
        end
      end
      byte_pos_nxt = byte_pos_r + 16'd1;
    end
  end

  always_comb begin
    res = '0;
    if (oversize_nxt) begin
      res.status = STATUS_TOO_LONG;
    end else if (byte_pos_nxt < FixedHdrBytes) begin
      res.status = STATUS_SHORT_HDR;
    end else if (is_extension(next_type_nxt) || hdr_start_nxt > {1'b0, byte_pos_nxt}) begin
      res.status = STATUS_TRUNC_EXT;
    end else begin
      res.status         = STATUS_OK;
      res.upper_protocol = next_type_nxt;
      res.payload_offset = hdr_start_nxt[15:0];
      res.payload_length = byte_pos_nxt - hdr_start_nxt[15:0];
    end
  end

  assign res_valid = fire && byte_last;

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && byte_last)) begin
      byte_pos_r  <= '0;
      next_type_r <= '0;
      hdr_start_r <= HdrStartInit;
      oversize_r  <= 1'b0;
      pending_r   <= '0;
    end else if (fire) begin
      byte_pos_r  <= byte_pos_nxt;
      next_type_r <= next_type_nxt;
      hdr_start_r <= hdr_start_nxt;
      oversize_r  <= oversize_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

[src/ipv6w_out_reg.sv]
// ----------------------------------------------------------------------------
// ipv6w_out_reg
// Result register that holds one packet summary until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6w_out_reg import ipv6w_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    res_valid,
  input  wire result_t                 res,
  output logic                         advance,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OutDataWidth-1:0]      out_tdata
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign advance   = !valid_r || out_tready;
  assign valid_nxt = res_valid ? 1'b1 : ((valid_r && out_tready) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OutDataWidth - $bits(result_t)){1'b0}}, res_r};

endmodule

`default_nettype wire
